// ----- hw/rtl/fmd_pkg.sv -----
// Package for the FM discriminator and decimator.
// Holds the beat structs, controller codes, fixed widths and the CORDIC arctangent table.
// No dependencies.
package fmd_pkg;

    // Width of the binary angle, where 2^(ANGLE_BITS-1) stands for pi.
    localparam int ANGLE_BITS = 16;
    // Raw angle can reach +pi, so one extra bit.
    localparam int DEMOD_W    = ANGLE_BITS + 1;
    // Angle after DC removal.
    localparam int DEMOD2_W   = DEMOD_W + 2;
    // DC estimate carries 16 fraction bits.
    localparam int DC_W       = DEMOD_W + 17;
    // Conjugate product components.
    localparam int RE_W       = 19;
    // CORDIC vector and angle accumulator (pi = 2^31).
    localparam int X_W        = 36;
    localparam int Z_W        = 34;
    // CORDIC step index width (table holds 24 entries).
    localparam int K_W        = 5;
    localparam int DECIM_W    = 11;
    localparam int ALPHA_W    = 16;
    localparam int CFG_W      = 16;

    // Configuration register indexes.
    localparam logic CFG_DECIM = 1'b0;
    localparam logic CFG_ALPHA = 1'b1;

    // Function codes of an input beat.
    localparam logic FUNC_PAIR  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] i_sample;
        logic [7:0] q_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] audio_value;
        logic               partial;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_MUL, ST_PRE, ST_ITER, ST_ROUND, ST_DCMUL,
        ST_DCUPD, ST_DCSUB, ST_ACC, ST_CHECK, ST_DIVINIT, ST_DIV, ST_FIX, ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_STORE, OP_MUL, OP_PRE, OP_ITER, OP_ROUND, OP_DCMUL,
        OP_DCUPD, OP_DCSUB, OP_ACC, OP_DIVINIT, OP_DIVSTEP, OP_DIVFIX, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op            op;
        logic [K_W-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic is_flush;
        logic seen_first;
        logic count_zero;
        logic dc_on;
        logic group_full;
        logic div_last;
        logic out_free;
    } t_status;

    // atan(2^-k) with pi = 2^31.
    function automatic logic [31:0] atan_of(input logic [K_W-1:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/fmd_ctrl.sv -----
// Sequencing state machine of the FM discriminator and decimator.
// Depends on fmd_pkg for the state, command and status types.
module fmd_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  fmd_pkg::t_status i_status,
    output fmd_pkg::t_cmd   o_cmd,
    output logic            o_in_stall
);
    import fmd_pkg::*;

    localparam logic [K_W-1:0] K_LAST = K_W'(CORDIC_STEPS - 1);

    t_state r_state, n_state;
    logic [K_W-1:0] r_k, n_k;

    // State and step counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_DECODE;
            ST_DECODE: begin
                if (i_status.is_flush) begin
                    n_state = i_status.count_zero ? ST_IDLE : ST_DIVINIT;
                end else if (!i_status.seen_first) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:     n_state = ST_PRE;
            ST_PRE: begin
                n_state = ST_ITER;
                n_k     = '0;
            end
            ST_ITER: begin
                n_k = r_k + 1'b1;
                if (r_k == K_LAST) n_state = ST_ROUND;
            end
            ST_ROUND:   n_state = i_status.dc_on ? ST_DCMUL : ST_ACC;
            ST_DCMUL:   n_state = ST_DCUPD;
            ST_DCUPD:   n_state = ST_DCSUB;
            ST_DCSUB:   n_state = ST_ACC;
            ST_ACC:     n_state = ST_CHECK;
            ST_CHECK:   n_state = i_status.group_full ? ST_DIVINIT : ST_IDLE;
            ST_DIVINIT: n_state = ST_DIV;
            ST_DIV:     if (i_status.div_last) n_state = ST_FIX;
            ST_FIX:     n_state = ST_OUT;
            ST_OUT:     if (i_status.out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.k    = r_k;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE:    if (i_in_valid) o_cmd.op = OP_LOAD;
            ST_DECODE: begin
                if (!i_status.is_flush && !i_status.seen_first) o_cmd.op = OP_STORE;
            end
            ST_MUL:     o_cmd.op = OP_MUL;
            ST_PRE:     o_cmd.op = OP_PRE;
            ST_ITER:    o_cmd.op = OP_ITER;
            ST_ROUND:   o_cmd.op = OP_ROUND;
            ST_DCMUL:   o_cmd.op = OP_DCMUL;
            ST_DCUPD:   o_cmd.op = OP_DCUPD;
            ST_DCSUB:   o_cmd.op = OP_DCSUB;
            ST_ACC:     o_cmd.op = OP_ACC;
            ST_CHECK:   o_cmd.op = OP_NONE;
            ST_DIVINIT: o_cmd.op = OP_DIVINIT;
            ST_DIV:     o_cmd.op = OP_DIVSTEP;
            ST_FIX:     o_cmd.op = OP_DIVFIX;
            ST_OUT:     if (i_status.out_free) o_cmd.op = OP_EMIT;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    // The CORDIC step index never runs past the last step.
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ITER) |-> (r_k <= K_LAST))
        else $error("CORDIC step index out of range");
    // A pair that was already stored leads into the multiply step.
    a_decode_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> $past(r_state) == ST_DECODE)
        else $error("multiply step entered out of sequence");
    // The input side is stalled whenever the sequencer is busy.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("input taken while busy");

endmodule

// ----- hw/rtl/fmd_datapath.sv -----
// Datapath of the FM discriminator and decimator: conjugate product, CORDIC,
// DC removal, group accumulator, restoring divider and output register. Uses fmd_pkg.
module fmd_datapath #(
    parameter int MAX_DECIM = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fmd_pkg::t_cmd        i_cmd,
    input  fmd_pkg::t_in_item    i_in_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [fmd_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                 i_out_stall,
    output fmd_pkg::t_status     o_status,
    output logic                 o_out_valid,
    output fmd_pkg::t_out_item   o_out_data
);
    import fmd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DECIM + 1);
    localparam int LIM_W  = (CNT_W > DECIM_W) ? CNT_W : DECIM_W;
    localparam int SUM_W  = DEMOD2_W + CNT_W;
    localparam int DIVC_W = $clog2(SUM_W + 1);
    localparam int PROD_W = DC_W + 1 + ALPHA_W + 1;
    localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(MAX_DECIM);

    // Configuration registers.
    logic [DECIM_W-1:0] r_decim;
    logic [ALPHA_W-1:0] r_alpha;

    // Sample and CORDIC registers.
    logic                      r_func;
    logic signed [8:0]         r_ci, r_cq, r_last_i, r_last_q;
    logic                      r_seen;
    logic signed [RE_W-1:0]    r_re, r_im;
    logic                      r_zero;
    logic signed [X_W-1:0]     r_x, r_y;
    logic signed [Z_W-1:0]     r_z;

    // DC removal and group registers.
    logic signed [DEMOD2_W-1:0] r_demod;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [DC_W-1:0]     r_dc;
    logic signed [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]           r_count;

    // Divider and output registers.
    logic                       r_neg;
    logic [SUM_W-1:0]           r_quo;
    logic [CNT_W-1:0]           r_rem;
    logic [DIVC_W-1:0]          r_div_cnt;
    logic signed [15:0]         r_res;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic [LIM_W-1:0]           lim;
    logic                       out_free;
    logic signed [X_W-1:0]      x0, y0, xs, ys;
    logic signed [Z_W-1:0]      atan_z, z_rnd;
    logic signed [DC_W:0]       dc_diff;
    logic signed [PROD_W-1:0]   dc_sum;
    logic signed [DC_W-1:0]     dc_rnd;
    logic [CNT_W:0]             div_shift;
    logic signed [SUM_W:0]      q_signed;

    // Group limit: zero acts as one, large values clamp to the maximum.
    always_comb begin
        if (r_decim == '0) begin
            lim = LIM_W'(1);
        end else if (LIM_W'(r_decim) > LIM_MAX) begin
            lim = LIM_MAX;
        end else begin
            lim = LIM_W'(r_decim);
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Status to the controller.
    always_comb begin
        o_status.is_flush   = (r_func == FUNC_FLUSH);
        o_status.seen_first = r_seen;
        o_status.count_zero = (r_count == '0);
        o_status.dc_on      = (r_alpha != '0);
        o_status.group_full = (LIM_W'(r_count) >= lim);
        o_status.div_last   = (r_div_cnt == DIVC_W'(1));
        o_status.out_free   = out_free;
    end

    // Combinational helpers for the CORDIC, DC and divider steps.
    always_comb begin
        x0       = X_W'(r_re) <<< 16;
        y0       = X_W'(r_im) <<< 16;
        xs       = r_x >>> i_cmd.k;
        ys       = r_y >>> i_cmd.k;
        atan_z   = Z_W'(atan_of(i_cmd.k));
        z_rnd    = (r_z + (Z_W'(1) <<< (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
        dc_diff  = ((DC_W + 1)'(r_demod) <<< 16) - (DC_W + 1)'(r_dc);
        dc_sum   = PROD_W'(r_dc) + (r_prod >>> 16);
        dc_rnd   = (r_dc + DC_W'(32768)) >>> 16;
        div_shift = {r_rem, r_quo[SUM_W-1]};
        if (r_neg) begin
            q_signed = -$signed({1'b0, r_quo}) - (SUM_W + 1)'(r_rem != '0);
        end else begin
            q_signed = $signed({1'b0, r_quo});
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim <= DECIM_W'(1);
            r_alpha <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DECIM: r_decim <= i_cfg_data[DECIM_W-1:0];
                CFG_ALPHA: r_alpha <= i_cfg_data[ALPHA_W-1:0];
                default:   r_decim <= r_decim;
            endcase
        end
    end

    // Control state with reset: stored pair flag, DC level, group, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_last_i    <= '0;
            r_last_q    <= '0;
            r_dc        <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result takes the register; otherwise a taken beat frees it.
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_STORE: begin
                    r_last_i <= r_ci;
                    r_last_q <= r_cq;
                    r_seen   <= 1'b1;
                end
                OP_MUL: begin
                    r_last_i <= r_ci;
                    r_last_q <= r_cq;
                end
                OP_DCUPD:   r_dc <= DC_W'(dc_sum);
                OP_ACC: begin
                    r_sum   <= r_sum + SUM_W'(r_demod);
                    r_count <= r_count + 1'b1;
                end
                OP_DIVINIT: r_div_cnt <= DIVC_W'(SUM_W);
                OP_DIVSTEP: r_div_cnt <= r_div_cnt - 1'b1;
                OP_DIVFIX: begin
                    r_sum   <= '0;
                    r_count <= '0;
                end
                default:    r_seen <= r_seen;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_func <= i_in_data.func;
                r_ci   <= $signed({1'b0, i_in_data.i_sample}) - 9'sd127;
                r_cq   <= $signed({1'b0, i_in_data.q_sample}) - 9'sd127;
            end
            OP_MUL: begin
                r_re <= RE_W'(r_ci) * RE_W'(r_last_i) + RE_W'(r_cq) * RE_W'(r_last_q);
                r_im <= RE_W'(r_cq) * RE_W'(r_last_i) - RE_W'(r_ci) * RE_W'(r_last_q);
            end
            OP_PRE: begin
                r_zero <= (r_re == '0) && (r_im == '0);
                if (r_re < 0) begin
                    if (r_im >= 0) begin
                        r_x <= y0;
                        r_y <= -x0;
                        r_z <= Z_W'(1073741824);
                    end else begin
                        r_x <= -y0;
                        r_y <= x0;
                        r_z <= -Z_W'(1073741824);
                    end
                end else begin
                    r_x <= x0;
                    r_y <= y0;
                    r_z <= '0;
                end
            end
            OP_ITER: begin
                if (r_y > 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_z;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_z;
                end
            end
            OP_ROUND:   r_demod <= r_zero ? '0 : DEMOD2_W'(DEMOD_W'(z_rnd));
            OP_DCMUL:   r_prod  <= PROD_W'(dc_diff) * PROD_W'($signed({1'b0, r_alpha}));
            OP_DCSUB:   r_demod <= r_demod - DEMOD2_W'(dc_rnd);
            OP_DIVINIT: begin
                r_neg <= r_sum[SUM_W-1];
                r_quo <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
                r_rem <= '0;
            end
            OP_DIVSTEP: begin
                if (div_shift >= {1'b0, r_count}) begin
                    r_rem <= CNT_W'(div_shift - {1'b0, r_count});
                    r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= div_shift[CNT_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                end
            end
            OP_DIVFIX: begin
                if (q_signed > (SUM_W + 1)'(32767)) begin
                    r_res <= 16'sh7FFF;
                end else if (q_signed < -(SUM_W + 1)'(32768)) begin
                    r_res <= -16'sh8000;
                end else begin
                    r_res <= 16'(q_signed);
                end
            end
            OP_EMIT: begin
                r_out.audio_value <= r_res;
                r_out.partial     <= r_func;
            end
            default: r_func <= r_func;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The pending count never exceeds the group limit ceiling.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_DECIM))
        else $error("group count above maximum");
    // A result is only loaded when the output register is free.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT) |-> out_free)
        else $error("result overwrote a pending beat");
    // A division never starts on an empty group.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIVINIT) |-> (r_count != '0))
        else $error("division by an empty group");

endmodule

// ----- hw/rtl/fm_iq_discriminator_decimator.sv -----
// FM polar discriminator with DC removal and decimation (top level).
// Instantiates fmd_ctrl and fmd_datapath; uses fmd_pkg.
//
// One input beat is handled at a time. A sample pair passes through the
// conjugate multiply, the iterative CORDIC and the accumulator, with the
// DC multiply, update and subtract steps added when the DC tracking gain
// is nonzero. The first pair after reset is only stored.
// A pair that completes a group, or a flush with values pending, also runs
// the one-bit-per-cycle restoring divider over SUM_W quotient bits that forms
// the floor mean, where SUM_W = ANGLE_BITS + 3 + clog2(MAX_DECIM + 1)
// (30 at the defaults). The finished result sits in an output register, so
// the next beat is taken while it waits; the block holds only if a second
// result is ready before the first is taken.
module fm_iq_discriminator_decimator #(
    parameter int MAX_DECIM    = 1024,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  fmd_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output fmd_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [fmd_pkg::CFG_W-1:0] i_cfg_data
);
    import fmd_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    fmd_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Arithmetic and storage.
    fmd_datapath #(
        .MAX_DECIM(MAX_DECIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- tb/sv/fm_iq_discriminator_decimator_tb.sv -----
// Testbench for the FM discriminator and decimator: directed table, then random beats.
// Predicts every output beat with its own fixed-point discriminator model and checks it.
// Depends on fmd_pkg and fm_iq_discriminator_decimator.
module fm_iq_discriminator_decimator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fmd_pkg::*;

    typedef struct {
        logic       func;
        logic [7:0] i_s;
        logic [7:0] q_s;
        logic       has_exp;
        logic [15:0] exp_audio;
        logic       exp_part;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    // Predictor state.
    longint      m_decim;
    longint      m_alpha;
    longint      m_last_i;
    longint      m_last_q;
    bit          m_seen;
    longint      m_dc;
    longint      m_sum;
    longint      m_count;

    t_out_item   audio_expected[$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    t_row        rows[$];

    fm_iq_discriminator_decimator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    // Phase of re + j*im as a 16-bit binary angle.
    function automatic longint phase_of(longint re, longint im);
        longint x, y, z, t, xs, ys;
        longint steps[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861};
        if (re == 0 && im == 0) return 0;
        x = re * 65536;
        y = im * 65536;
        z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 1073741824;
            end else begin
                t = x; x = -y; y = t; z = -1073741824;
            end
        end
        for (int k = 0; k < 16; k++) begin
            xs = floor_shift(x, k);
            ys = floor_shift(y, k);
            if (y > 0) begin
                x += ys; y -= xs; z += steps[k];
            end else begin
                x -= ys; y += xs; z -= steps[k];
            end
        end
        return floor_shift(z + (64'sd1 <<< 15), 16);
    endfunction

    // Emit the floor mean of the pending group.
    function automatic void close_group(bit part);
        longint m, q;
        t_out_item r;
        q = m_sum / m_count;
        if ((m_sum % m_count) != 0 && m_sum < 0) q--;
        m = q;
        if (m > 32767) m = 32767;
        if (m < -32768) m = -32768;
        r.audio_value = m[15:0];
        r.partial = part;
        audio_expected.push_back(r);
        m_sum = 0;
        m_count = 0;
    endfunction

    // Advance the predictor by one accepted beat.
    function automatic void predict_audio(t_in_item it);
        longint ci, cq, demod, diff, lim;
        if (it.func == FUNC_FLUSH) begin
            if (m_count != 0) close_group(1'b1);
            return;
        end
        ci = longint'(it.i_sample) - 127;
        cq = longint'(it.q_sample) - 127;
        if (!m_seen) begin
            m_last_i = ci; m_last_q = cq; m_seen = 1'b1;
            return;
        end
        demod = phase_of(ci * m_last_i + cq * m_last_q, cq * m_last_i - ci * m_last_q);
        m_last_i = ci;
        m_last_q = cq;
        if (m_alpha != 0) begin
            diff = demod * 65536 - m_dc;
            m_dc += floor_shift(diff * m_alpha, 16);
            demod -= floor_shift(m_dc + 32768, 16);
        end
        m_sum += demod;
        m_count++;
        lim = m_decim;
        if (lim == 0) lim = 1;
        if (lim > 1024) lim = 1024;
        if (m_count >= lim) close_group(1'b0);
    endfunction

    // Check output beats against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (audio_expected.size() == 0) begin
                $error("unexpected output beat audio_value=%0d", o_out_data.audio_value);
                errors++;
            end else begin
                e = audio_expected.pop_front();
                if (o_out_data.audio_value !== e.audio_value) begin
                    $error("audio_value expected %0d actual %0d",
                           e.audio_value, o_out_data.audio_value);
                    errors++;
                end
                if (o_out_data.partial !== e.partial) begin
                    $error("partial expected %0b actual %0b", e.partial, o_out_data.partial);
                    errors++;
                end
            end
        end
    end

    // Receiver stall, with a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_off) i_out_stall <= 1'b1;
        else i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic write_reg(logic idx, int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DECIM) m_decim = value & 16'h7FF;
        else m_alpha = value & 16'hFFFF;
    endtask

    // Offer one beat, with a random gap ahead of it, until it is taken.
    // Valid stays high on return so that beats can follow back to back.
    task automatic send_beat(logic func, logic [7:0] i_s, logic [7:0] q_s);
        t_in_item it;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        it.func = func;
        it.i_sample = i_s;
        it.q_sample = q_s;
        i_in_data <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_audio(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (audio_expected.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (80) @(negedge i_clk);
    endtask

    task automatic add_row(logic f, logic [7:0] a, logic [7:0] b, logic he = 0,
                           logic [15:0] ea = 0, logic ep = 0);
        t_row r;
        r.func = f; r.i_s = a; r.q_s = b; r.has_exp = he; r.exp_audio = ea; r.exp_part = ep;
        rows.push_back(r);
    endtask

    initial begin
        t_row r;
        int df, base_i, base_q;
        errors = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_DECIM;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        m_decim = 1; m_alpha = 0; m_last_i = 0; m_last_q = 0;
        m_seen = 0; m_dc = 0; m_sum = 0; m_count = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table: flush on empty, first pair stored, zero vector, extremes.
        add_row(FUNC_FLUSH, 8'h00, 8'h00);
        add_row(FUNC_PAIR, 8'd255, 8'd127);
        add_row(FUNC_PAIR, 8'd255, 8'd127, 1, 16'd0, 0);
        add_row(FUNC_PAIR, 8'd127, 8'd127, 1, 16'd0, 0);
        add_row(FUNC_PAIR, 8'd0, 8'd127, 1, 16'd0, 0);
        add_row(FUNC_PAIR, 8'd255, 8'd127);
        add_row(FUNC_PAIR, 8'd127, 8'd255);
        add_row(FUNC_PAIR, 8'd0, 8'd0);
        add_row(FUNC_PAIR, 8'd255, 8'd255);
        add_row(FUNC_PAIR, 8'd127, 8'd0);
        add_row(FUNC_PAIR, 8'd255, 8'd0);
        add_row(FUNC_FLUSH, 8'hFF, 8'hFF);
        foreach (rows[j]) begin
            r = rows[j];
            send_beat(r.func, r.i_s, r.q_s);
            if (r.has_exp && (audio_expected.size() == 0 ||
                audio_expected[$].audio_value !== r.exp_audio)) begin
                $error("directed row %0d audio_value expected %0d", j, r.exp_audio);
                errors++;
            end
        end
        drain();

        // With DC removal on: partial groups, flush, then lowered factors of one and zero.
        write_reg(CFG_DECIM, 4);
        write_reg(CFG_ALPHA, 65535);
        send_beat(FUNC_PAIR, 8'd200, 8'd50);
        send_beat(FUNC_PAIR, 8'd10, 8'd240);
        send_beat(FUNC_FLUSH, 8'd0, 8'd0);
        send_beat(FUNC_PAIR, 8'd130, 8'd20);
        send_beat(FUNC_PAIR, 8'd30, 8'd30);
        drain();
        write_reg(CFG_DECIM, 1);
        send_beat(FUNC_PAIR, 8'd77, 8'd180);
        drain();
        write_reg(CFG_DECIM, 0);
        send_beat(FUNC_PAIR, 8'd90, 8'd1);
        drain();

        // Random phases over several settings, cycling through four idling mixes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            case (ph)
                0: df = 1;
                1: df = 2;
                2: df = 3;
                3: df = 5;
                4: df = 2047;
                5: df = 1024;
                default: df = $urandom_range(8, 1);
            endcase
            write_reg(CFG_DECIM, df);
            write_reg(CFG_ALPHA, (ph == 6) ? 0 : (ph == 7) ? 65535 : $urandom_range(65535));
            if (ph == 0) fork
                begin
                    hold_off = 1'b1;
                    repeat (400) @(negedge i_clk);
                    hold_off = 1'b0;
                end
            join_none
            for (int j = 0; j < 160; j++) begin
                // Mostly a rotating carrier with noise; some arbitrary bytes and flushes.
                if ($urandom_range(99) < 4) begin
                    send_beat(FUNC_FLUSH, 8'($urandom), 8'($urandom));
                end else if ($urandom_range(99) < 30) begin
                    send_beat(FUNC_PAIR, 8'($urandom), 8'($urandom));
                end else begin
                    base_i = 127 + int'(120.0 * $cos(j * 0.3 * (ph + 1)));
                    base_q = 127 + int'(120.0 * $sin(j * 0.3 * (ph + 1)));
                    send_beat(FUNC_PAIR, 8'(base_i + $urandom_range(6) - 3),
                              8'(base_q + $urandom_range(6) - 3));
                end
            end
            send_beat(FUNC_FLUSH, 8'd0, 8'd0);
            drain();
        end
        if (errors == 0 && audio_expected.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- fm_iq_discriminator_decimator.f -----
hw/rtl/fmd_pkg.sv
hw/rtl/fmd_ctrl.sv
hw/rtl/fmd_datapath.sv
hw/rtl/fm_iq_discriminator_decimator.sv
tb/sv/fm_iq_discriminator_decimator_tb.sv
